### hw/rtl/utc_timestamp_to_epoch_unit_assert.svh
// assertion macros for the timestamp parser rtl, used by utc_conv
// expects clk_i and rst_ni to exist in the module that uses them
`ifndef UTC_TIMESTAMP_TO_EPOCH_UNIT_ASSERT_SVH
`define UTC_TIMESTAMP_TO_EPOCH_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge outside reset
`define UTC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define UTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define UTC_ASSERT_ALWAYS(lbl, expr, msg)
`define UTC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/utc_pkg.sv
// package for the timestamp to epoch unit: beat types, character codes, tables
// no dependencies
package utc_pkg;

  localparam logic [4:0] StrLast = 5'd26;
  localparam logic [4:0] StrLen  = 5'd27;

  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;
  localparam logic [7:0] ChrDash  = 8'h2d;
  localparam logic [7:0] ChrColon = 8'h3a;
  localparam logic [7:0] ChrT     = 8'h54;
  localparam logic [7:0] ChrZ     = 8'h5a;

  localparam logic [13:0] YearMin = 14'd1970;
  localparam logic [13:0] YearMax = 14'd9999;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } utc_in_t;

  typedef struct packed {
    logic        ok;
    logic [37:0] epoch_seconds;
  } utc_out_t;

  // collected fields of one finished string
  typedef struct packed {
    logic        pre_ok;  // format clean and length right
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } utc_fields_t;

  // "backup-" prefix
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] chr;
    unique case (idx)
      3'd0:    chr = 8'h62;
      3'd1:    chr = 8'h61;
      3'd2:    chr = 8'h63;
      3'd3:    chr = 8'h6b;
      3'd4:    chr = 8'h75;
      3'd5:    chr = 8'h70;
      3'd6:    chr = 8'h2d;
      default: chr = 8'h00;
    endcase
    return chr;
  endfunction

  // day offset of a month in a march-based year, (153*mp+2)/5
  function automatic logic [8:0] month_offset(input logic [3:0] mon);
    logic [8:0] off;
    unique case (mon)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

### hw/rtl/utc_parse.sv
// character parser: position, format flag and decimal field accumulators
// depends on utc_pkg; hands finished fields to the conversion pipeline
module utc_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  utc_pkg::utc_in_t     in_data_i,
  output logic                 fld_valid_o,
  input  logic                 fld_stall_i,
  output utc_pkg::utc_fields_t fld_o
);
  import utc_pkg::*;

  logic [4:0]  pos_q, pos_d;
  logic        bad_q, bad_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d, day_q, day_d;
  logic [6:0]  hour_q, hour_d, minute_q, minute_d, second_q, second_d;
  logic        fld_valid_q;
  utc_fields_t fld_q;

  logic       accept;
  logic [7:0] chr;
  logic       is_digit;
  logic [3:0] dig;

  assign in_stall_o = fld_valid_q && fld_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign chr        = in_data_i.char_code;
  assign is_digit   = (chr >= ChrZero) && (chr <= ChrNine);
  assign dig        = 4'(chr - ChrZero);

  always_comb begin
    pos_d    = (pos_q < StrLen) ? 5'(pos_q + 5'd1) : pos_q;
    bad_d    = bad_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    hour_d   = hour_q;
    minute_d = minute_q;
    second_d = second_q;
    case (pos_q) inside
      [5'd0:5'd6]: begin
        if (chr != prefix_char(pos_q[2:0])) bad_d = 1'b1;
      end
      [5'd7:5'd10]: begin
        if (is_digit) year_d = 14'(year_q * 14'd10 + 14'(dig));
        else bad_d = 1'b1;
      end
      5'd12, 5'd13: begin
        if (is_digit) month_d = 7'(month_q * 7'd10 + 7'(dig));
        else bad_d = 1'b1;
      end
      5'd15, 5'd16: begin
        if (is_digit) day_d = 7'(day_q * 7'd10 + 7'(dig));
        else bad_d = 1'b1;
      end
      5'd18, 5'd19: begin
        if (is_digit) hour_d = 7'(hour_q * 7'd10 + 7'(dig));
        else bad_d = 1'b1;
      end
      5'd21, 5'd22: begin
        if (is_digit) minute_d = 7'(minute_q * 7'd10 + 7'(dig));
        else bad_d = 1'b1;
      end
      5'd24, 5'd25: begin
        if (is_digit) second_d = 7'(second_q * 7'd10 + 7'(dig));
        else bad_d = 1'b1;
      end
      5'd11, 5'd14: begin
        if (chr != ChrDash) bad_d = 1'b1;
      end
      5'd17: begin
        if (chr != ChrT) bad_d = 1'b1;
      end
      5'd20, 5'd23: begin
        if (chr != ChrColon) bad_d = 1'b1;
      end
      5'd26: begin
        if (chr != ChrZ) bad_d = 1'b1;
      end
      default: bad_d = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      bad_q       <= 1'b0;
      year_q      <= '0;
      month_q     <= '0;
      day_q       <= '0;
      hour_q      <= '0;
      minute_q    <= '0;
      second_q    <= '0;
      fld_valid_q <= 1'b0;
    end else begin
      if (accept && in_data_i.is_last) begin
        fld_valid_q <= 1'b1;
      end else if (!fld_stall_i) begin
        fld_valid_q <= 1'b0;
      end
      if (accept) begin
        if (in_data_i.is_last) begin
          pos_q    <= '0;
          bad_q    <= 1'b0;
          year_q   <= '0;
          month_q  <= '0;
          day_q    <= '0;
          hour_q   <= '0;
          minute_q <= '0;
          second_q <= '0;
        end else begin
          pos_q    <= pos_d;
          bad_q    <= bad_d;
          year_q   <= year_d;
          month_q  <= month_d;
          day_q    <= day_d;
          hour_q   <= hour_d;
          minute_q <= minute_d;
          second_q <= second_d;
        end
      end
    end
  end

  // field register, loaded with the string's final values on the last beat
  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.is_last) begin
      fld_q.pre_ok <= !bad_d && (pos_q == StrLast);
      fld_q.year   <= year_d;
      fld_q.month  <= month_d;
      fld_q.day    <= day_d;
      fld_q.hour   <= hour_d;
      fld_q.minute <= minute_d;
      fld_q.second <= second_d;
    end
  end

  assign fld_valid_o = fld_valid_q;
  assign fld_o       = fld_q;

endmodule

### hw/rtl/utc_conv.sv
// days-from-civil conversion pipeline with the output register
// depends on utc_pkg and the assertion macro header
`include "utc_timestamp_to_epoch_unit_assert.svh"
module utc_conv (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fld_valid_i,
  output logic                 fld_stall_o,
  input  utc_pkg::utc_fields_t fld_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output utc_pkg::utc_out_t    out_data_o
);
  import utc_pkg::*;

  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, eno;

  // stage 1 logic
  logic        range_ok;
  logic [13:0] yy;
  logic [26:0] prod100;
  logic [21:0] y365;
  logic [8:0]  doy;
  logic [18:0] tod;

  logic        good1_q;
  logic [21:0] y365_q;
  logic [11:0] yq4_q;
  logic [7:0]  q100_q;
  logic [8:0]  doy_q;
  logic [18:0] tod1_q;

  logic [22:0] days_sum;
  logic        good2_q;
  logic [21:0] days_q;
  logic [18:0] tod2_q;

  logic        good3_q;
  logic [37:0] prod_q;
  logic [18:0] tod3_q;

  logic [37:0] epoch;
  utc_out_t    out_q;

  assign eno         = !vo_q || !out_stall_i;
  assign en3         = !v3_q || eno;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign fld_stall_o = !en1;

  always_comb begin
    range_ok = fld_i.pre_ok
      && (fld_i.year >= YearMin) && (fld_i.year <= YearMax)
      && (fld_i.month >= 7'd1) && (fld_i.month <= 7'd12)
      && (fld_i.day >= 7'd1) && (fld_i.day <= 7'd31)
      && (fld_i.hour <= 7'd23) && (fld_i.minute <= 7'd59)
      && (fld_i.second <= 7'd60);
    // january and february count into the previous year
    yy      = (fld_i.month <= 7'd2) ? 14'(fld_i.year - 14'd1) : fld_i.year;
    // yy/100 by reciprocal, exact for this range
    prod100 = 27'(yy) * 27'd5243;
    y365    = 22'(yy) * 22'd365;
    doy     = 9'(month_offset(fld_i.month[3:0]) + 9'(fld_i.day) - 9'd1);
    tod     = 19'(19'(fld_i.hour) * 19'd3600 + 19'(fld_i.minute) * 19'd60
                  + 19'(fld_i.second));
  end

  assign days_sum = 23'(y365_q) + 23'(yq4_q) + 23'(q100_q[7:2]) + 23'(doy_q)
                  - 23'(q100_q) - 23'd719468;
  assign epoch    = 38'(prod_q + 38'(tod3_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= fld_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (eno) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      good1_q <= range_ok;
      y365_q  <= y365;
      yq4_q   <= yy[13:2];
      q100_q  <= prod100[26:19];
      doy_q   <= doy;
      tod1_q  <= tod;
    end
    if (en2) begin
      good2_q <= good1_q;
      days_q  <= days_sum[21:0];
      tod2_q  <= tod1_q;
    end
    if (en3) begin
      good3_q <= good2_q;
      prod_q  <= 38'(days_q) * 38'd86400;
      tod3_q  <= tod2_q;
    end
    if (eno) begin
      out_q.ok            <= good3_q && (epoch != '0);
      out_q.epoch_seconds <= (good3_q && (epoch != '0)) ? epoch : '0;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  `UTC_ASSERT_ALWAYS(a_ok_nonzero, !(vo_q && out_q.ok) || (out_q.epoch_seconds != '0), "ok result with zero epoch")
  `UTC_ASSERT_ALWAYS(a_bad_zero, !(vo_q && !out_q.ok) || (out_q.epoch_seconds == '0), "rejected result with nonzero epoch")
  `UTC_ASSERT_ALWAYS(a_stall_full, !fld_stall_o || (v1_q && v2_q && v3_q && vo_q), "pipeline stalls with a free stage")
  `UTC_ASSERT_NEXT(a_stage_hold, v2_q && !en3, v2_q, "held stage lost its beat")

endmodule

### hw/rtl/utc_timestamp_to_epoch_unit.sv
// top level of the timestamp string to unix epoch unit
// depends on utc_pkg, utc_parse and utc_conv
//
//   channel  dir  handshake            payload
//   in       in   in_valid_i/stall_o   utc_in_t: char_code, is_last
//   out      out  out_valid_o/stall_i  utc_out_t: ok, epoch_seconds
//
// one character beat is taken every cycle while in_stall_o is low
// out_valid_o rises after a last-character beat has gone through the field register
// (loaded on the edge that takes the beat) and then the four stages; a stall can
// hold the result in any of them
// reset is asynchronous and active low; it clears the parser and all valids
// the pipeline compacts bubbles, so input keeps flowing while results wait
// until all five result slots hold beats; then in_stall_o follows out_stall_i
module utc_timestamp_to_epoch_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  utc_pkg::utc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output utc_pkg::utc_out_t out_data_o
);
  import utc_pkg::*;

  // finished fields between parser and conversion pipeline
  logic        fld_valid;
  logic        fld_stall;
  utc_fields_t fld;

  // character beats: position check, digit accumulation
  utc_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .fld_valid_o(fld_valid),
    .fld_stall_i(fld_stall),
    .fld_o      (fld)
  );

  // range checks, day count, seconds, output register
  utc_conv u_conv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fld_valid_i(fld_valid),
    .fld_stall_o(fld_stall),
    .fld_i      (fld),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

### bench/tb_utc_timestamp_to_epoch_unit.sv
// self-checking bench for the timestamp string to unix epoch unit
// depends on utc_pkg and the utc_timestamp_to_epoch_unit rtl; drives beats and checks results
module tb_utc_timestamp_to_epoch_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import utc_pkg::*;

  // fixed text at the start of every well-formed string
  localparam string PrefixText = "backup-";
  localparam int unsigned RandChars = 400;
  localparam int unsigned RandStrings = 16;
  localparam int unsigned DrainCycles = 20;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  utc_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  utc_out_t out_data_o;

  utc_timestamp_to_epoch_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("utc_timestamp_to_epoch_unit test failed");
    $finish;
  end

  // ------------------------------------------------------------------
  // parser model: position, format flag and the six decimal fields
  // ------------------------------------------------------------------
  logic [4:0]  str_pos;
  logic        fmt_bad;
  logic [13:0] year_digits;
  logic [6:0]  month_digits;
  logic [6:0]  day_digits;
  logic [6:0]  hour_digits;
  logic [6:0]  minute_digits;
  logic [6:0]  second_digits;

  // epoch results still owed by the dut, oldest first
  utc_out_t pending_epochs[$];
  utc_out_t want_res;

  int unsigned mismatch_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned chars_sent;
  int unsigned strings_sent;

  function automatic bit is_digit(input logic [7:0] c);
    return (c >= ChrZero) && (c <= ChrNine);
  endfunction

  // days-from-civil, every term non-negative since year >= 1969
  function automatic logic [37:0] civil_to_epoch(
    input longint unsigned y, input longint unsigned m, input longint unsigned d,
    input longint unsigned hh, input longint unsigned mi, input longint unsigned ss);
    longint unsigned yy, era, yoe, mp, doy, doe, days;
    yy   = y - ((m <= 2) ? 1 : 0);
    era  = yy / 400;
    yoe  = yy - era * 400;
    mp   = (m > 2) ? (m - 3) : (m + 9);
    doy  = (153 * mp + 2) / 5 + d - 1;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468;
    return 38'(days * 86400 + hh * 3600 + mi * 60 + ss);
  endfunction

  task automatic clear_parser();
    str_pos       = '0;
    fmt_bad       = 1'b0;
    year_digits   = '0;
    month_digits  = '0;
    day_digits    = '0;
    hour_digits   = '0;
    minute_digits = '0;
    second_digits = '0;
  endtask

  // one accepted character beat; a last beat yields the expected result
  task automatic parse_char(input utc_in_t beat, output bit has_res, output utc_out_t res);
    logic [4:0]  p;
    logic [7:0]  c;
    logic [37:0] secs;
    bit          good;
    p       = str_pos;
    c       = beat.char_code;
    has_res = 1'b0;
    res     = '0;
    if (p < 7) begin
      if (c != 8'(PrefixText[p])) fmt_bad = 1'b1;
    end else if (p inside {[7:10], 12, 13, 15, 16, 18, 19, 21, 22, 24, 25}) begin
      // digit slots: a non-digit flags the string and leaves the field alone
      if (!is_digit(c)) begin
        fmt_bad = 1'b1;
      end else begin
        case (p)
          7, 8, 9, 10: year_digits   = year_digits * 14'd10 + 14'(c - ChrZero);
          12, 13:      month_digits  = month_digits * 7'd10 + 7'(c - ChrZero);
          15, 16:      day_digits    = day_digits * 7'd10 + 7'(c - ChrZero);
          18, 19:      hour_digits   = hour_digits * 7'd10 + 7'(c - ChrZero);
          21, 22:      minute_digits = minute_digits * 7'd10 + 7'(c - ChrZero);
          default:     second_digits = second_digits * 7'd10 + 7'(c - ChrZero);
        endcase
      end
    end else begin
      case (p)
        11, 14:  if (c != ChrDash) fmt_bad = 1'b1;
        17:      if (c != ChrT) fmt_bad = 1'b1;
        20, 23:  if (c != ChrColon) fmt_bad = 1'b1;
        26:      if (c != ChrZ) fmt_bad = 1'b1;
        default: fmt_bad = 1'b1;  // past the end of the string
      endcase
    end
    if (p < StrLen) str_pos = p + 5'd1;
    if (beat.is_last) begin
      good = !fmt_bad && (p == StrLast)
          && (year_digits >= YearMin) && (year_digits <= YearMax)
          && (month_digits >= 1) && (month_digits <= 12)
          && (day_digits >= 1) && (day_digits <= 31)
          && (hour_digits <= 23) && (minute_digits <= 59) && (second_digits <= 60);
      secs = '0;
      if (good) begin
        secs = civil_to_epoch(year_digits, month_digits, day_digits,
                              hour_digits, minute_digits, second_digits);
        if (secs == '0) good = 1'b0;
      end
      has_res = 1'b1;
      res.ok = good;
      res.epoch_seconds = good ? secs : '0;
      clear_parser();
    end
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // ------------------------------------------------------------------
  // sender: one beat per character, random idle before each beat
  // ------------------------------------------------------------------
  task automatic send_text(input byte unsigned txt[$], input bit fixed, input utc_out_t fixed_res);
    utc_in_t  beat;
    utc_out_t res;
    bit       has_res;
    for (int i = 0; i < txt.size(); i++) begin
      beat.char_code = txt[i];
      beat.is_last   = (i == txt.size() - 1);
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_data_i  <= beat;
      // hold the beat until the edge that takes it
      do @(posedge clk_i); while (in_stall_o);
      parse_char(beat, has_res, res);
      chars_sent++;
      if (has_res) pending_epochs = {pending_epochs, (fixed ? fixed_res : res)};
    end
  endtask

  // drop valid and let every owed result come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_epochs.size() != 0) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_field(input int unsigned lo, input int unsigned hi,
                                             input int unsigned wide_hi);
    if ($urandom_range(99) < 85) return $urandom_range(hi, lo);
    return $urandom_range(wide_hi, 0);
  endfunction

  // mostly well-formed strings with random fields, plus damaged ones and noise
  task automatic make_random_text(output byte unsigned txt[$]);
    string       s;
    int unsigned kind, yr, n;
    txt.delete();
    kind = $urandom_range(99);
    if (kind < 88) begin
      case ($urandom_range(9))
        0, 1, 2, 3: yr = $urandom_range(2100, 1970);
        4:          yr = $urandom_range(1972, 1969);
        5:          yr = $urandom_range(9999, 1970);
        default:    yr = pick_field(1970, 9999, 9999);
      endcase
      s = $sformatf("backup-%04d-%02d-%02dT%02d:%02d:%02dZ", yr,
                    pick_field(1, 12, 99), pick_field(1, 31, 99), pick_field(0, 23, 99),
                    pick_field(0, 59, 99), pick_field(0, 60, 99));
      for (int i = 0; i < s.len(); i++) txt.insert(txt.size(), s[i]);
      if (kind >= 70 && kind < 80) begin
        // one character replaced by an arbitrary byte
        txt[$urandom_range(26)] = 8'($urandom_range(255));
      end else if (kind >= 80) begin
        // cut short or run on past the end
        if ($urandom_range(1)) begin
          n = $urandom_range(26, 1);
          while (txt.size() > n) void'(txt.pop_back());
        end else begin
          n = $urandom_range(10, 1);
          repeat (n) txt.insert(txt.size(), 8'($urandom_range(255)));
        end
      end
    end else begin
      // raw noise, sometimes behind a good prefix
      if ($urandom_range(1)) for (int i = 0; i < 7; i++) txt.insert(txt.size(), PrefixText[i]);
      n = $urandom_range(40, 1);
      repeat (n) txt.insert(txt.size(), 8'($urandom_range(255)));
    end
  endtask

  // ------------------------------------------------------------------
  // receiver: random stall, checks each result beat against the oldest
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_epochs.size() == 0) begin
        report_mismatch("result beat with nothing owed", out_data_o.epoch_seconds, 0);
      end else begin
        want_res = pending_epochs.pop_front();
        if (out_data_o.ok !== want_res.ok)
          report_mismatch("ok", out_data_o.ok, want_res.ok);
        if (out_data_o.epoch_seconds !== want_res.epoch_seconds)
          report_mismatch("epoch_seconds", out_data_o.epoch_seconds, want_res.epoch_seconds);
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // ------------------------------------------------------------------
  // directed table: typed results only where plain to read off
  // ------------------------------------------------------------------
  typedef struct {
    string       text;
    bit          fixed;
    utc_out_t    res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(input string text, input bit fixed, input bit ok,
                         input logic [37:0] secs);
    dir_row_t row;
    row.text = text;
    row.fixed = fixed;
    row.res.ok = ok;
    row.res.epoch_seconds = secs;
    dir_rows = {dir_rows, row};
  endtask

  initial begin
    byte unsigned txt[$];
    int unsigned  phase;
    int unsigned  last_phase;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    chars_sent     = 0;
    strings_sent   = 0;
    clear_parser();

    // epoch zero is rejected, one second past it is the smallest valid
    add_row("backup-1970-01-01T00:00:00Z", 1'b1, 1'b0, 38'd0);
    add_row("backup-1970-01-01T00:00:01Z", 1'b1, 1'b1, 38'd1);
    // largest year, last day, leap second
    add_row("backup-9999-12-31T23:59:60Z", 1'b1, 1'b1, 38'd253402300800);
    add_row("backup-1969-12-31T23:59:59Z", 1'b1, 1'b0, 38'd0);
    add_row("backup-2024-13-01T00:00:00Z", 1'b1, 1'b0, 38'd0);
    add_row("backup-2024-00-10T00:00:00Z", 1'b1, 1'b0, 38'd0);
    add_row("backup-2024-01-32T00:00:00Z", 1'b1, 1'b0, 38'd0);
    add_row("backup-2024-01-00T00:00:00Z", 1'b1, 1'b0, 38'd0);
    add_row("backup-2024-01-01T24:00:00Z", 1'b1, 1'b0, 38'd0);
    add_row("backup-2024-01-01T00:60:00Z", 1'b1, 1'b0, 38'd0);
    add_row("backup-2024-01-01T00:00:61Z", 1'b1, 1'b0, 38'd0);
    // non-digit inside a field
    add_row("backup-2024-0a-01T00:00:00Z", 1'b1, 1'b0, 38'd0);
    // prefix, separator and terminator mismatches
    add_row("Backup-2024-01-01T00:00:00Z", 1'b1, 1'b0, 38'd0);
    add_row("backup-2024-01-01 00:00:00Z", 1'b1, 1'b0, 38'd0);
    add_row("backup-2024-01-01T00:00:00z", 1'b1, 1'b0, 38'd0);
    // wrong length: short, long, single character
    add_row("backup-2024-01-01T00:00:00", 1'b1, 1'b0, 38'd0);
    add_row("backup-2024-01-01T00:00:00Zxyz", 1'b1, 1'b0, 38'd0);
    add_row("Z", 1'b1, 1'b0, 38'd0);
    // day past month end carries into the next month; leap day in 2000, march 1st in 2100
    add_row("backup-2023-02-31T12:34:56Z", 1'b0, 1'b0, 38'd0);
    add_row("backup-2000-02-29T06:30:15Z", 1'b0, 1'b0, 38'd0);
    add_row("backup-2100-03-01T23:59:59Z", 1'b0, 1'b0, 38'd0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows with no idling on either side
    foreach (dir_rows[r]) begin
      txt.delete();
      for (int i = 0; i < dir_rows[r].text.len(); i++) txt.insert(txt.size(), dir_rows[r].text[i]);
      send_text(txt, dir_rows[r].fixed, dir_rows[r].res);
      strings_sent++;
    end
    // sender holds off until every owed result is back
    wait_drained();

    // random strings, cycling through the idle and stall mixes
    chars_sent   = 0;
    strings_sent = 0;
    last_phase   = 0;
    while (chars_sent < RandChars || strings_sent < RandStrings) begin
      phase = (strings_sent / 4) % 4;
      if (phase != last_phase) begin
        if (phase == 2) wait_drained();
        last_phase = phase;
      end
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      make_random_text(txt);
      send_text(txt, 1'b0, '0);
      strings_sent++;
    end

    // wait out the owed results, then the pipeline depth
    wait_drained();
    recv_stall_pct = 0;
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("utc_timestamp_to_epoch_unit test passed");
    end else begin
      $display("utc_timestamp_to_epoch_unit test failed");
    end
    $finish;
  end

endmodule

### utc_timestamp_to_epoch_unit.f
+incdir+hw/rtl
hw/rtl/utc_pkg.sv
hw/rtl/utc_parse.sv
hw/rtl/utc_conv.sv
hw/rtl/utc_timestamp_to_epoch_unit.sv
bench/tb_utc_timestamp_to_epoch_unit.sv
